// ----- rtl/core/smma_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the GEMM kernel.
`default_nettype none

package smma_pkg;

	localparam int MAX_M_DEF = 16;
	localparam int MAX_N_DEF = 16;
	localparam int MAX_K_DEF = 16;

	localparam int DIM_W      = 5;
	localparam int DIM_MAX    = 2 ** DIM_W - 1;
	localparam int OP_W       = 3;
	localparam int IDX_W      = 4;
	localparam int DATA_W     = 32;
	localparam int AB_W       = 16;
	localparam int GAIN_W     = 16;
	localparam int ST_W       = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int FRAC_W     = 8;
	localparam int AVAL_W     = 2 * AB_W - FRAC_W;
	localparam int MAC_W      = AVAL_W + AB_W;
	localparam int PROD_W     = GAIN_W + DATA_W;
	localparam int SUM_W      = PROD_W - FRAC_W + 2;

	localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);
	localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(16);
	localparam logic signed [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(256);

	// item opcodes
	localparam logic [OP_W-1:0] OP_WR_A    = 3'd0;
	localparam logic [OP_W-1:0] OP_WR_B    = 3'd1;
	localparam logic [OP_W-1:0] OP_WR_C    = 3'd2;
	localparam logic [OP_W-1:0] OP_COMPUTE = 3'd3;
	localparam logic [OP_W-1:0] OP_RD_C    = 3'd4;

	// result status
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_BADOP = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_M_ROWS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_N_COLS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BETA      = 3'd4;

	// datapath operations
	typedef logic [3:0] dp_op_t;
	localparam dp_op_t DP_NOP     = 4'd0;
	localparam dp_op_t DP_ITEM    = 4'd1;
	localparam dp_op_t DP_C_ZERO  = 4'd2;
	localparam dp_op_t DP_CB_RD   = 4'd3;
	localparam dp_op_t DP_CB_MUL  = 4'd4;
	localparam dp_op_t DP_CB_WR   = 4'd5;
	localparam dp_op_t DP_A_RD    = 4'd6;
	localparam dp_op_t DP_A_MUL   = 4'd7;
	localparam dp_op_t DP_MAC_RD  = 4'd8;
	localparam dp_op_t DP_MAC_MUL = 4'd9;
	localparam dp_op_t DP_MAC_WR  = 4'd10;

	typedef struct packed {
		dp_op_t           op;
		logic [DIM_W-1:0] i;
		logic [DIM_W-1:0] j;
		logic [DIM_W-1:0] t;
		logic             clr_clip;
		logic             out_load;
	} smma_cmd_t;

	typedef struct packed {
		logic [DIM_W-1:0] m_eff;
		logic [DIM_W-1:0] n_eff;
		logic [DIM_W-1:0] k_eff;
		logic             beta_zero;
		logic             beta_one;
	} smma_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/scaled_matrix_multiply_accumulate.sv -----
// Top level of the fixed-point GEMM kernel C = beta*C + alpha*A*B on local memories.
//
// Channels: the input channel (in_valid/in_ready) carries one item: opcode, row_index,
// col_index, write_value. The output channel (out_valid/out_ready) returns exactly one
// result per item: read_value, status, saturated. The config channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) writes m_rows, n_cols, inner_len, alpha_gain, beta_gain; it is
// always ready and should only be used while the block is idle.
// Sequencing: write A/B/C and bad opcode load the result on accept, one item per cycle
// while each result is taken; read C waits in S_RD_WAIT for the registered memory read.
// compute clears C for beta 0, leaves it for beta 1.0 and scales it otherwise, then reads
// and alpha-scales each A element and accumulates it into its C row. Scaling and
// accumulation are read, multiply, write on C; no item is accepted until compute is done.
// Reset: config registers return to 16/16/16, alpha 1.0, beta 0; the output empties.
// Memory contents are not cleared; read only entries that were written.
// A stalled receiver holds the result in the output register; the next item is
// taken in the cycle the result leaves.
`default_nettype none

module scaled_matrix_multiply_accumulate #(
	parameter int MAX_M = smma_pkg::MAX_M_DEF,
	parameter int MAX_N = smma_pkg::MAX_N_DEF,
	parameter int MAX_K = smma_pkg::MAX_K_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [smma_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [smma_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [smma_pkg::OP_W-1:0]          opcode,
	input  wire logic [smma_pkg::IDX_W-1:0]         row_index,
	input  wire logic [smma_pkg::IDX_W-1:0]         col_index,
	input  wire logic signed [smma_pkg::DATA_W-1:0] write_value,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [smma_pkg::DATA_W-1:0]      read_value,
	output logic [smma_pkg::ST_W-1:0]               status,
	output logic                                    saturated
);
	import smma_pkg::*;

	smma_cmd_t cmd;
	smma_sts_t sts;

	assign cfg_ready = 1'b1;

	smma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	smma_dp #(.MAX_M(MAX_M), .MAX_N(MAX_N), .MAX_K(MAX_K)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.opcode      (opcode),
		.row_index   (row_index),
		.col_index   (col_index),
		.write_value (write_value),
		.cmd         (cmd),
		.sts         (sts),
		.read_value  (read_value),
		.status      (status),
		.saturated   (saturated)
	);

endmodule

`default_nettype wire

// ----- rtl/core/smma_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module smma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                                        clk,
	input  wire logic                                        wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                            wr_data,
	input  wire logic                                        rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                            rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/smma_ctrl.sv -----
// Controller: item handshake, loop counters and sequencing of the compute pass.
`default_nettype none

module smma_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [smma_pkg::OP_W-1:0] opcode,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	input  wire smma_pkg::smma_sts_t       sts,
	output smma_pkg::smma_cmd_t            cmd
);
	import smma_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_RD_WAIT = 4'd1;
	localparam logic [3:0] S_C_ZERO  = 4'd2;
	localparam logic [3:0] S_CB_RD   = 4'd3;
	localparam logic [3:0] S_CB_MUL  = 4'd4;
	localparam logic [3:0] S_CB_WR   = 4'd5;
	localparam logic [3:0] S_A_RD    = 4'd6;
	localparam logic [3:0] S_A_MUL   = 4'd7;
	localparam logic [3:0] S_MAC_RD  = 4'd8;
	localparam logic [3:0] S_MAC_MUL = 4'd9;
	localparam logic [3:0] S_MAC_WR  = 4'd10;
	localparam logic [3:0] S_DONE    = 4'd11;

	logic [3:0]       state_q, state_d;
	logic [DIM_W-1:0] i_q, i_d, j_q, j_d, t_q, t_d;
	logic             out_valid_q, out_valid_d;
	logic             accept;
	logic             i_last, j_last, t_last;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign i_last = (i_q == sts.m_eff - DIM_ONE);
	assign j_last = (j_q == sts.n_eff - DIM_ONE);
	assign t_last = (t_q == sts.k_eff - DIM_ONE);

	always_comb begin
		state_d      = state_q;
		i_d          = i_q;
		j_d          = j_q;
		t_d          = t_q;
		out_valid_d  = out_valid_q && !out_ready;
		cmd          = '0;
		cmd.op       = DP_NOP;
		cmd.i        = i_q;
		cmd.j        = j_q;
		cmd.t        = t_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.op = DP_ITEM;
					i_d    = '0;
					j_d    = '0;
					t_d    = '0;
					if (opcode == OP_RD_C) begin
						state_d = S_RD_WAIT;
					end else if (opcode == OP_COMPUTE) begin
						cmd.clr_clip = 1'b1;
						if (sts.beta_one) begin
							state_d = S_A_RD;
						end else if (sts.beta_zero) begin
							state_d = S_C_ZERO;
						end else begin
							state_d = S_CB_RD;
						end
					end else begin
						cmd.out_load = 1'b1;
						out_valid_d  = 1'b1;
					end
				end
			end
			S_RD_WAIT: begin
				cmd.out_load = 1'b1;
				out_valid_d  = 1'b1;
				state_d      = S_IDLE;
			end
			S_C_ZERO: begin
				cmd.op = DP_C_ZERO;
				if (!j_last) begin
					j_d = j_q + DIM_ONE;
				end else begin
					j_d = '0;
					if (i_last) begin
						i_d     = '0;
						state_d = S_A_RD;
					end else begin
						i_d = i_q + DIM_ONE;
					end
				end
			end
			S_CB_RD: begin
				cmd.op  = DP_CB_RD;
				state_d = S_CB_MUL;
			end
			S_CB_MUL: begin
				cmd.op  = DP_CB_MUL;
				state_d = S_CB_WR;
			end
			S_CB_WR: begin
				cmd.op  = DP_CB_WR;
				state_d = S_CB_RD;
				if (!j_last) begin
					j_d = j_q + DIM_ONE;
				end else begin
					j_d = '0;
					if (i_last) begin
						i_d     = '0;
						state_d = S_A_RD;
					end else begin
						i_d = i_q + DIM_ONE;
					end
				end
			end
			S_A_RD: begin
				cmd.op  = DP_A_RD;
				state_d = S_A_MUL;
			end
			S_A_MUL: begin
				cmd.op  = DP_A_MUL;
				state_d = S_MAC_RD;
			end
			S_MAC_RD: begin
				cmd.op  = DP_MAC_RD;
				state_d = S_MAC_MUL;
			end
			S_MAC_MUL: begin
				cmd.op  = DP_MAC_MUL;
				state_d = S_MAC_WR;
			end
			S_MAC_WR: begin
				cmd.op = DP_MAC_WR;
				// column loop innermost, then k, then row
				if (!j_last) begin
					j_d     = j_q + DIM_ONE;
					state_d = S_MAC_RD;
				end else begin
					j_d = '0;
					if (!t_last) begin
						t_d     = t_q + DIM_ONE;
						state_d = S_A_RD;
					end else begin
						t_d = '0;
						if (!i_last) begin
							i_d     = i_q + DIM_ONE;
							state_d = S_A_RD;
						end else begin
							i_d     = '0;
							state_d = S_DONE;
						end
					end
				end
			end
			S_DONE: begin
				cmd.out_load = 1'b1;
				out_valid_d  = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			t_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			i_q         <= i_d;
			j_q         <= j_d;
			t_q         <= t_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/smma_dp.sv -----
// Datapath: configuration registers, A/B/C memories, multipliers, saturation, result register.
`default_nettype none

module smma_dp #(
	parameter int MAX_M = smma_pkg::MAX_M_DEF,
	parameter int MAX_N = smma_pkg::MAX_N_DEF,
	parameter int MAX_K = smma_pkg::MAX_K_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	input  wire logic [smma_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [smma_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic [smma_pkg::OP_W-1:0]             opcode,
	input  wire logic [smma_pkg::IDX_W-1:0]            row_index,
	input  wire logic [smma_pkg::IDX_W-1:0]            col_index,
	input  wire logic signed [smma_pkg::DATA_W-1:0]    write_value,
	input  wire smma_pkg::smma_cmd_t                   cmd,
	output smma_pkg::smma_sts_t                        sts,
	output logic signed [smma_pkg::DATA_W-1:0]         read_value,
	output logic [smma_pkg::ST_W-1:0]                  status,
	output logic                                       saturated
);
	import smma_pkg::*;

	localparam int A_DEPTH = MAX_M * MAX_K;
	localparam int B_DEPTH = MAX_K * MAX_N;
	localparam int C_DEPTH = MAX_M * MAX_N;
	localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
	localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
	localparam int C_AW    = (C_DEPTH > 1) ? $clog2(C_DEPTH) : 1;
	localparam logic [DIM_W-1:0] M_CAP = (MAX_M > DIM_MAX) ? DIM_W'(DIM_MAX) : DIM_W'(MAX_M);
	localparam logic [DIM_W-1:0] N_CAP = (MAX_N > DIM_MAX) ? DIM_W'(DIM_MAX) : DIM_W'(MAX_N);
	localparam logic [DIM_W-1:0] K_CAP = (MAX_K > DIM_MAX) ? DIM_W'(DIM_MAX) : DIM_W'(MAX_K);

	// configuration
	logic [DIM_W-1:0]         m_rows_q, n_cols_q, inner_len_q;
	logic signed [GAIN_W-1:0] alpha_q, beta_q;
	logic [DIM_W-1:0]         m_eff, n_eff, k_eff;

	// item decode
	logic             item;
	logic [DIM_W-1:0] r_ext, c_ext;
	logic             a_ok, b_ok, c_ok;
	logic [ST_W-1:0]  item_st;
	logic [OP_W-1:0]  op_q;
	logic [ST_W-1:0]  st_q;

	// memory ports
	logic [DIM_W-1:0] a_r, a_c, b_r, b_c, c_r, c_c;
	logic [31:0]      a_addr_full, b_addr_full, c_addr_full;
	logic [A_AW-1:0]  a_addr;
	logic [B_AW-1:0]  b_addr;
	logic [C_AW-1:0]  c_addr;
	logic             a_we, b_we, c_we, a_re, b_re, c_re;
	logic [DATA_W-1:0] c_wdata;
	logic [AB_W-1:0]  a_rdata, b_rdata;
	logic [DATA_W-1:0] c_rdata;

	// arithmetic
	logic signed [2*AB_W-1:0] alpha_prod;
	logic signed [AVAL_W-1:0] aval_q;
	logic signed [MAC_W-1:0]  mac_prod;
	logic signed [PROD_W-1:0] beta_prod;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] prod_sh;
	logic signed [SUM_W-1:0]  term, c_add, sum;
	logic                     sat_hi, sat_lo, clip_q;
	logic [DATA_W-1:0]        sat_val;
	logic                     wr_stage;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_rows_q    <= DIM_RST;
			n_cols_q    <= DIM_RST;
			inner_len_q <= DIM_RST;
			alpha_q     <= GAIN_UNITY;
			beta_q      <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_M_ROWS:    m_rows_q    <= cfg_data[DIM_W-1:0];
				REG_N_COLS:    n_cols_q    <= cfg_data[DIM_W-1:0];
				REG_INNER_LEN: inner_len_q <= cfg_data[DIM_W-1:0];
				REG_ALPHA:     alpha_q     <= $signed(cfg_data[GAIN_W-1:0]);
				REG_BETA:      beta_q      <= $signed(cfg_data[GAIN_W-1:0]);
				default:       ;
			endcase
		end
	end

	// dimensions clamp into [1, MAX]
	assign m_eff = (m_rows_q == '0) ? DIM_ONE : ((m_rows_q > M_CAP) ? M_CAP : m_rows_q);
	assign n_eff = (n_cols_q == '0) ? DIM_ONE : ((n_cols_q > N_CAP) ? N_CAP : n_cols_q);
	assign k_eff = (inner_len_q == '0) ? DIM_ONE : ((inner_len_q > K_CAP) ? K_CAP : inner_len_q);

	assign sts.m_eff     = m_eff;
	assign sts.n_eff     = n_eff;
	assign sts.k_eff     = k_eff;
	assign sts.beta_zero = (beta_q == '0);
	assign sts.beta_one  = (beta_q == GAIN_UNITY);

	assign item  = (cmd.op == DP_ITEM);
	assign r_ext = DIM_W'(row_index);
	assign c_ext = DIM_W'(col_index);
	assign a_ok  = (r_ext < m_eff) && (c_ext < k_eff);
	assign b_ok  = (r_ext < k_eff) && (c_ext < n_eff);
	assign c_ok  = (r_ext < m_eff) && (c_ext < n_eff);

	always_comb begin
		unique case (opcode)
			OP_WR_A:    item_st = a_ok ? ST_OK : ST_RANGE;
			OP_WR_B:    item_st = b_ok ? ST_OK : ST_RANGE;
			OP_WR_C:    item_st = c_ok ? ST_OK : ST_RANGE;
			OP_COMPUTE: item_st = ST_OK;
			OP_RD_C:    item_st = c_ok ? ST_OK : ST_RANGE;
			default:    item_st = ST_BADOP;
		endcase
	end

	always_ff @(posedge clk) begin
		if (item) begin
			op_q <= opcode;
			st_q <= item_st;
		end
	end

	// addressing: the item's indices, or the loop counters during a compute pass
	assign a_r = item ? r_ext : cmd.i;
	assign a_c = item ? c_ext : cmd.t;
	assign b_r = item ? r_ext : cmd.t;
	assign b_c = item ? c_ext : cmd.j;
	assign c_r = item ? r_ext : cmd.i;
	assign c_c = item ? c_ext : cmd.j;

	assign a_addr_full = 32'(a_r) * 32'(MAX_K) + 32'(a_c);
	assign b_addr_full = 32'(b_r) * 32'(MAX_N) + 32'(b_c);
	assign c_addr_full = 32'(c_r) * 32'(MAX_N) + 32'(c_c);
	assign a_addr      = a_addr_full[A_AW-1:0];
	assign b_addr      = b_addr_full[B_AW-1:0];
	assign c_addr      = c_addr_full[C_AW-1:0];

	assign wr_stage = (cmd.op == DP_CB_WR) || (cmd.op == DP_MAC_WR);

	assign a_we = item && (opcode == OP_WR_A) && a_ok;
	assign b_we = item && (opcode == OP_WR_B) && b_ok;
	assign c_we = (item && (opcode == OP_WR_C) && c_ok) || (cmd.op == DP_C_ZERO) || wr_stage;
	assign a_re = (cmd.op == DP_A_RD);
	assign b_re = (cmd.op == DP_MAC_RD);
	assign c_re = (item && (opcode == OP_RD_C)) || (cmd.op == DP_CB_RD) || (cmd.op == DP_MAC_RD);

	assign c_wdata = item ? write_value : ((cmd.op == DP_C_ZERO) ? '0 : sat_val);

	smma_ram #(.WIDTH(AB_W), .DEPTH(A_DEPTH)) u_a_ram (
		.clk     (clk),
		.wr_en   (a_we),
		.wr_addr (a_addr),
		.wr_data (write_value[AB_W-1:0]),
		.rd_en   (a_re),
		.rd_addr (a_addr),
		.rd_data (a_rdata)
	);

	smma_ram #(.WIDTH(AB_W), .DEPTH(B_DEPTH)) u_b_ram (
		.clk     (clk),
		.wr_en   (b_we),
		.wr_addr (b_addr),
		.wr_data (write_value[AB_W-1:0]),
		.rd_en   (b_re),
		.rd_addr (b_addr),
		.rd_data (b_rdata)
	);

	smma_ram #(.WIDTH(DATA_W), .DEPTH(C_DEPTH)) u_c_ram (
		.clk     (clk),
		.wr_en   (c_we),
		.wr_addr (c_addr),
		.wr_data (c_wdata),
		.rd_en   (c_re),
		.rd_addr (c_addr),
		.rd_data (c_rdata)
	);

	// aval = (alpha * a) >>> 8, exact in 24 bits
	assign alpha_prod = alpha_q * $signed(a_rdata);

	always_ff @(posedge clk) begin
		if (cmd.op == DP_A_MUL) begin
			aval_q <= alpha_prod[2*AB_W-1:FRAC_W];
		end
	end

	assign mac_prod  = aval_q * $signed(b_rdata);
	assign beta_prod = beta_q * $signed(c_rdata);

	always_ff @(posedge clk) begin
		if (cmd.op == DP_CB_MUL) begin
			prod_q <= beta_prod;
		end else if (cmd.op == DP_MAC_MUL) begin
			prod_q <= {{(PROD_W-MAC_W){mac_prod[MAC_W-1]}}, mac_prod};
		end
	end

	// C read data is held from the read stage; it only adds in for accumulation
	assign prod_sh = prod_q >>> FRAC_W;
	assign term    = $signed(prod_sh[SUM_W-1:0]);
	assign c_add   = (cmd.op == DP_MAC_WR) ?
		{{(SUM_W-DATA_W){c_rdata[DATA_W-1]}}, $signed(c_rdata)} : '0;
	assign sum     = term + c_add;
	assign sat_hi  = !sum[SUM_W-1] && (|sum[SUM_W-2:DATA_W-1]);
	assign sat_lo  = sum[SUM_W-1] && !(&sum[SUM_W-2:DATA_W-1]);
	assign sat_val = sat_hi ? {1'b0, {(DATA_W-1){1'b1}}} :
		(sat_lo ? {1'b1, {(DATA_W-1){1'b0}}} : sum[DATA_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= 1'b0;
		end else if (cmd.clr_clip) begin
			clip_q <= 1'b0;
		end else if (wr_stage && (sat_hi || sat_lo)) begin
			clip_q <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (item) begin
				read_value <= '0;
				status     <= item_st;
				saturated  <= 1'b0;
			end else begin
				read_value <= ((op_q == OP_RD_C) && (st_q == ST_OK)) ? $signed(c_rdata) : '0;
				status     <= st_q;
				saturated  <= (op_q == OP_COMPUTE) ? clip_q : 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/smma_checker.sv -----
// Port-level assertions for the GEMM kernel, bound to the top level.
`default_nettype none

module smma_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               cfg_valid,
	input wire logic                               cfg_ready,
	input wire logic [smma_pkg::CFG_IDX_W-1:0]     cfg_index,
	input wire logic [smma_pkg::CFG_DATA_W-1:0]    cfg_data,
	input wire logic                               in_valid,
	input wire logic                               in_ready,
	input wire logic [smma_pkg::OP_W-1:0]          opcode,
	input wire logic [smma_pkg::IDX_W-1:0]         row_index,
	input wire logic [smma_pkg::IDX_W-1:0]         col_index,
	input wire logic signed [smma_pkg::DATA_W-1:0] write_value,
	input wire logic                               out_valid,
	input wire logic                               out_ready,
	input wire logic signed [smma_pkg::DATA_W-1:0] read_value,
	input wire logic [smma_pkg::ST_W-1:0]          status,
	input wire logic                               saturated
);
	import smma_pkg::*;

	// a held result does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(status)
			&& $stable(saturated))
		else $error("result changed while stalled");

	// only a good read returns data
	a_data_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (read_value == '0))
		else $error("data returned with error status");

	a_sat_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (status == ST_OK) && (read_value == '0))
		else $error("saturation flag on a non-compute result");

	// bad opcode answers in the next cycle
	a_badop: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode != OP_WR_A) && (opcode != OP_WR_B)
			&& (opcode != OP_WR_C) && (opcode != OP_COMPUTE) && (opcode != OP_RD_C)
		|=> out_valid && (status == ST_BADOP))
		else $error("bad opcode not reported");

	// read C holds its result back, and the input off, while the memory read completes
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode == OP_RD_C) |=> !out_valid && !in_ready ##1 out_valid)
		else $error("read result timing wrong");

endmodule

bind scaled_matrix_multiply_accumulate smma_checker u_smma_checker (.*);

`default_nettype wire

// ----- dv/tb_scaled_matrix_multiply_accumulate.sv -----
// Self-checking testbench for the fixed-point GEMM kernel: directed, corner and random item traffic.
`timescale 1ns / 100ps

module tb_scaled_matrix_multiply_accumulate;
	import smma_pkg::*;

	localparam int TOTAL_ITEMS = 1850;
	localparam int QUIET_LIMIT = 100000;
	localparam int HOLD_CYCLES = 150;
	localparam int TAIL_CYCLES = 16;
	localparam int MAX_GAP     = 12;

	localparam logic [OP_W-1:0] OP_FIRST_BAD = OP_RD_C + 3'd1;
	localparam logic [OP_W-1:0] OP_LAST_BAD  = '1;

	localparam longint ACC_HI = 64'sd2147483647;
	localparam longint ACC_LO = -64'sd2147483648;

	typedef struct packed {
		logic [DATA_W-1:0] read_value;
		logic [ST_W-1:0]   status;
		logic              saturated;
	} gemm_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [OP_W-1:0]       opcode = '0;
	logic [IDX_W-1:0]      row_index = '0;
	logic [IDX_W-1:0]      col_index = '0;
	logic [DATA_W-1:0]     write_value = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [DATA_W-1:0]     read_value;
	logic [ST_W-1:0]       status;
	logic                  saturated;

	// shadow copy of the kernel's registers and stores
	logic [DIM_W-1:0]         rows_cfg, cols_cfg, depth_cfg;
	logic signed [GAIN_W-1:0] alpha_cfg, beta_cfg;
	logic signed [AB_W-1:0]   a_elems [MAX_M_DEF][MAX_K_DEF];
	logic signed [AB_W-1:0]   b_elems [MAX_K_DEF][MAX_N_DEF];
	logic signed [DATA_W-1:0] c_elems [MAX_M_DEF][MAX_N_DEF];
	bit                       a_known [MAX_M_DEF][MAX_K_DEF];
	bit                       b_known [MAX_K_DEF][MAX_N_DEF];
	bit                       c_known [MAX_M_DEF][MAX_N_DEF];

	gemm_result_t pending_results [$];

	bit offering = 1'b0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int stall_requests = 0;
	int items_sent = 0;
	int reg_writes = 0;
	int computes_run = 0;
	int clipped_runs = 0;
	int results_seen = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	scaled_matrix_multiply_accumulate i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.row_index   (row_index),
		.col_index   (col_index),
		.write_value (write_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_value  (read_value),
		.status      (status),
		.saturated   (saturated)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------- prediction ----------------

	function automatic int eff_dim(input logic [DIM_W-1:0] v, input int limit);
		if (v == 0)
			return 1;
		return (int'(v) > limit) ? limit : int'(v);
	endfunction

	function automatic int rows_eff();
		return eff_dim(rows_cfg, MAX_M_DEF);
	endfunction

	function automatic int cols_eff();
		return eff_dim(cols_cfg, MAX_N_DEF);
	endfunction

	function automatic int depth_eff();
		return eff_dim(depth_cfg, MAX_K_DEF);
	endfunction

	function automatic longint clip32(input longint v, inout bit hit);
		if (v > ACC_HI) begin
			hit = 1'b1;
			return ACC_HI;
		end
		if (v < ACC_LO) begin
			hit = 1'b1;
			return ACC_LO;
		end
		return v;
	endfunction

	// C = beta*C + alpha*A*B, arithmetic shifts floor toward minus infinity
	function automatic bit gemm_update_c();
		int m, n, k, i, j, t;
		bit hit;
		longint aval, sum;
		m = rows_eff();
		n = cols_eff();
		k = depth_eff();
		hit = 1'b0;
		for (i = 0; i < m; i++)
			for (j = 0; j < n; j++) begin
				if (beta_cfg == 0) begin
					c_elems[i][j] = '0;
					c_known[i][j] = 1'b1;
				end else if (beta_cfg != GAIN_UNITY) begin
					c_elems[i][j] = 32'(clip32((longint'(beta_cfg) * longint'(c_elems[i][j]))
						>>> FRAC_W, hit));
				end
			end
		for (i = 0; i < m; i++)
			for (t = 0; t < k; t++) begin
				aval = (longint'(alpha_cfg) * longint'(a_elems[i][t])) >>> FRAC_W;
				for (j = 0; j < n; j++) begin
					sum = longint'(c_elems[i][j]) + ((aval * longint'(b_elems[t][j])) >>> FRAC_W);
					c_elems[i][j] = 32'(clip32(sum, hit));
				end
			end
		return hit;
	endfunction

	function automatic gemm_result_t predict_gemm_item(input logic [OP_W-1:0] op,
			input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
		gemm_result_t res;
		int m, n, k;
		res = '0;
		m = rows_eff();
		n = cols_eff();
		k = depth_eff();
		case (op)
			OP_WR_A: begin
				if (r < m && c < k) begin
					a_elems[r][c] = v[AB_W-1:0];
					a_known[r][c] = 1'b1;
				end else
					res.status = ST_RANGE;
			end
			OP_WR_B: begin
				if (r < k && c < n) begin
					b_elems[r][c] = v[AB_W-1:0];
					b_known[r][c] = 1'b1;
				end else
					res.status = ST_RANGE;
			end
			OP_WR_C: begin
				if (r < m && c < n) begin
					c_elems[r][c] = v;
					c_known[r][c] = 1'b1;
				end else
					res.status = ST_RANGE;
			end
			OP_COMPUTE: begin
				res.saturated = gemm_update_c();
				computes_run++;
				if (res.saturated)
					clipped_runs++;
			end
			OP_RD_C: begin
				if (r < m && c < n)
					res.read_value = c_elems[r][c];
				else
					res.status = ST_RANGE;
			end
			default: res.status = ST_BADOP;
		endcase
		return res;
	endfunction

	// ---------------- checking ----------------

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		mismatches++;
		$display("mismatch on result %0d: %s got %h, expected %h", results_seen, what, got, want);
	endtask

	always @(posedge clk) begin : result_check
		gemm_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", read_value, '0);
			end else begin
				want = pending_results.pop_front();
				if (read_value !== want.read_value)
					report_mismatch("read_value", read_value, want.read_value);
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (saturated !== want.saturated)
					report_mismatch("saturated", 32'(saturated), 32'(want.saturated));
			end
		end
	end

	// result side: random stalls, plus long hold-offs on request
	initial begin : result_sink
		int hold_left;
		int served;
		hold_left = 0;
		served = 0;
		forever begin
			@(posedge clk);
			if (served != stall_requests) begin
				served = stall_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(99, 0) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	// ---------------- driving ----------------

	task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [DATA_W-1:0] v);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99, 0) < tx_idle_pct)
			gap++;
		if (gap > 0 && offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		repeat (gap) @(posedge clk);
		in_valid <= 1'b1;
		offering = 1'b1;
		opcode <= op;
		row_index <= r;
		col_index <= c;
		write_value <= v;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_gemm_item(op, r, c, v));
		items_sent++;
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		if (offering) begin
			in_valid <= 1'b0;
			offering = 1'b0;
		end
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_M_ROWS:    rows_cfg = data[DIM_W-1:0];
			REG_N_COLS:    cols_cfg = data[DIM_W-1:0];
			REG_INNER_LEN: depth_cfg = data[DIM_W-1:0];
			REG_ALPHA:     alpha_cfg = data;
			REG_BETA:      beta_cfg = data;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] rows, input logic [CFG_DATA_W-1:0] cols,
			input logic [CFG_DATA_W-1:0] depth, input logic [CFG_DATA_W-1:0] alpha,
			input logic [CFG_DATA_W-1:0] beta);
		drain();
		write_reg(REG_M_ROWS, rows);
		write_reg(REG_N_COLS, cols);
		write_reg(REG_INNER_LEN, depth);
		write_reg(REG_ALPHA, alpha);
		write_reg(REG_BETA, beta);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
	endtask

	// ---------------- random content ----------------

	function automatic logic [DATA_W-1:0] rand_ab_word();
		logic [DATA_W-1:0] w;
		w = $urandom();
		if ($urandom_range(1, 0))
			w[AB_W-1:0] = 16'($urandom_range(1023, 0)) - 16'd512;
		return w;
	endfunction

	function automatic logic [DATA_W-1:0] rand_c_word();
		logic [DATA_W-1:0] w;
		w = $urandom();
		if ($urandom_range(9, 0) < 6)
			w = 32'($urandom_range(131071, 0)) - 32'd65536;
		return w;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_gain();
		logic [CFG_DATA_W-1:0] g;
		case ($urandom_range(9, 0))
			0: g = '0;
			1: g = GAIN_UNITY;
			2: g = 16'h8000;
			3: g = 16'h7FFF;
			4, 5: g = 16'($urandom_range(1024, 0)) - 16'd512;
			default: g = 16'($urandom());
		endcase
		return g;
	endfunction

	// wide dims: upper data bits are junk, low five bits may fall outside 1..16
	function automatic logic [CFG_DATA_W-1:0] pick_dim(input bit wide);
		if (wide)
			return {11'($urandom()), 5'($urandom_range(DIM_MAX, 0))};
		return 16'($urandom_range(4, 1));
	endfunction

	// writes every A, B and C entry that the next compute would use but was never written
	task automatic fill_operands();
		int m, n, k, i, j;
		m = rows_eff();
		n = cols_eff();
		k = depth_eff();
		for (i = 0; i < m; i++)
			for (j = 0; j < k; j++)
				if (!a_known[i][j])
					send_item(OP_WR_A, 4'(i), 4'(j), rand_ab_word());
		for (i = 0; i < k; i++)
			for (j = 0; j < n; j++)
				if (!b_known[i][j])
					send_item(OP_WR_B, 4'(i), 4'(j), rand_ab_word());
		if (beta_cfg != 0)
			for (i = 0; i < m; i++)
				for (j = 0; j < n; j++)
					if (!c_known[i][j])
						send_item(OP_WR_C, 4'(i), 4'(j), rand_c_word());
	endtask

	task automatic send_compute();
		fill_operands();
		send_item(OP_COMPUTE, 4'($urandom()), 4'($urandom()), $urandom());
	endtask

	task automatic random_store_write(input logic [OP_W-1:0] op);
		int row_lim, col_lim;
		logic [IDX_W-1:0] r, c;
		case (op)
			OP_WR_A: begin
				row_lim = rows_eff();
				col_lim = depth_eff();
			end
			OP_WR_B: begin
				row_lim = depth_eff();
				col_lim = cols_eff();
			end
			default: begin
				row_lim = rows_eff();
				col_lim = cols_eff();
			end
		endcase
		if ($urandom_range(99, 0) < 12) begin
			r = 4'($urandom());
			c = 4'($urandom());
		end else begin
			r = 4'($urandom_range(row_lim - 1, 0));
			c = 4'($urandom_range(col_lim - 1, 0));
		end
		send_item(op, r, c, (op == OP_WR_C) ? rand_c_word() : rand_ab_word());
	endtask

	// a read that would hit a never-written entry becomes a write of it
	task automatic random_read();
		logic [IDX_W-1:0] r, c;
		if ($urandom_range(99, 0) < 15) begin
			r = 4'($urandom());
			c = 4'($urandom());
		end else begin
			r = 4'($urandom_range(rows_eff() - 1, 0));
			c = 4'($urandom_range(cols_eff() - 1, 0));
		end
		if (r < rows_eff() && c < cols_eff() && !c_known[r][c])
			send_item(OP_WR_C, r, c, rand_c_word());
		else
			send_item(OP_RD_C, r, c, $urandom());
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(99, 0);
		if (pick < 25)
			random_store_write(OP_WR_A);
		else if (pick < 50)
			random_store_write(OP_WR_B);
		else if (pick < 63)
			random_store_write(OP_WR_C);
		else if (pick < 83)
			random_read();
		else if (pick < 88)
			send_item(3'($urandom_range(OP_LAST_BAD, OP_FIRST_BAD)), 4'($urandom()),
				4'($urandom()), $urandom());
		else
			send_compute();
	endtask

	task automatic random_round();
		int len;
		bit wide;
		wide = ($urandom_range(9, 0) == 0);
		configure(pick_dim(wide), pick_dim(wide), pick_dim(wide), pick_gain(), pick_gain());
		len = $urandom_range(50, 20);
		repeat (len) random_item();
		send_compute();
		repeat (3) random_read();
	endtask

	// ---------------- tests ----------------

	task automatic test_directed_ops();
		int b;
		set_idling(0, 0);
		configure(16'd2, 16'd2, 16'd2, 16'h7FFF, 16'h8000);
		// upper half of A/B data is dropped
		send_item(OP_WR_A, 4'd0, 4'd0, 32'h1234_7FFF);
		send_item(OP_WR_A, 4'd0, 4'd1, 32'hFFFF_8000);
		send_item(OP_WR_A, 4'd1, 4'd0, 32'h0000_0100);
		send_item(OP_WR_A, 4'd1, 4'd1, 32'h8000_FF00);
		send_item(OP_WR_B, 4'd0, 4'd0, 32'h0000_7FFF);
		send_item(OP_WR_B, 4'd0, 4'd1, 32'h0000_8000);
		send_item(OP_WR_B, 4'd1, 4'd0, 32'hFFFF_FF80);
		send_item(OP_WR_B, 4'd1, 4'd1, 32'h7FFF_0200);
		send_item(OP_WR_C, 4'd0, 4'd0, 32'h7FFF_FFFF);
		send_item(OP_WR_C, 4'd0, 4'd1, 32'h8000_0000);
		send_item(OP_WR_C, 4'd1, 4'd0, 32'hFFFF_FF00);
		send_item(OP_WR_C, 4'd1, 4'd1, 32'h0000_0001);
		// each store has its own bounds
		send_item(OP_WR_A, 4'd2, 4'd0, 32'h0000_0001);
		send_item(OP_WR_A, 4'd0, 4'd2, 32'h0000_0001);
		send_item(OP_WR_B, 4'd2, 4'd1, 32'h0000_0001);
		send_item(OP_WR_B, 4'd1, 4'd2, 32'h0000_0001);
		send_item(OP_WR_C, 4'd15, 4'd15, 32'hFFFF_FFFF);
		send_item(OP_RD_C, 4'd0, 4'd2, 32'hFFFF_FFFF);
		for (b = OP_FIRST_BAD; b <= OP_LAST_BAD; b++)
			send_item(3'(b), 4'd15, 4'd15, 32'hFFFF_FFFF);
		// extreme gains against extreme C drive both saturation directions
		send_item(OP_COMPUTE, 4'd15, 4'd15, 32'hFFFF_FFFF);
		send_item(OP_RD_C, 4'd0, 4'd0, '0);
		send_item(OP_RD_C, 4'd0, 4'd1, '0);
		send_item(OP_RD_C, 4'd1, 4'd0, '0);
		send_item(OP_RD_C, 4'd1, 4'd1, '0);
	endtask

	// beta of one keeps C, zero clears it, anything else scales
	task automatic test_gain_cases();
		logic [CFG_DATA_W-1:0] alphas [5] = '{GAIN_UNITY, GAIN_UNITY, 16'h8000, 16'h7FFF, 16'hFF00};
		logic [CFG_DATA_W-1:0] betas [5] = '{GAIN_UNITY, 16'h0000, GAIN_UNITY, 16'h0001, 16'h8000};
		int g;
		set_idling(0, 0);
		for (g = 0; g < 5; g++) begin
			configure(16'd2, 16'd2, 16'd2, alphas[g], betas[g]);
			send_compute();
			send_item(OP_RD_C, 4'd0, 4'd0, $urandom());
			send_item(OP_RD_C, 4'd0, 4'd1, $urandom());
			send_item(OP_RD_C, 4'd1, 4'd0, $urandom());
			send_item(OP_RD_C, 4'd1, 4'd1, $urandom());
		end
	endtask

	task automatic test_dim_limits();
		set_idling(0, 0);
		// 31 and masked 0x30 both clamp to the full 16
		configure(16'd31, 16'd16, 16'h0030, pick_gain(), 16'hFF80);
		send_compute();
		repeat (6) random_read();
		// zero clamps to one
		configure(16'd0, 16'd0, 16'd0, 16'h8000, GAIN_UNITY);
		send_compute();
		send_item(OP_RD_C, 4'd0, 4'd0, $urandom());
		send_item(OP_RD_C, 4'd0, 4'd1, $urandom());
		send_item(OP_WR_A, 4'd0, 4'd1, rand_ab_word());
		send_item(OP_WR_B, 4'd1, 4'd0, rand_ab_word());
		configure(16'd17, 16'd1, 16'd31, 16'h7FFF, 16'h0000);
		send_compute();
		send_item(OP_RD_C, 4'd15, 4'd0, $urandom());
		send_item(OP_RD_C, 4'd0, 4'd1, $urandom());
	endtask

	// results back up while items keep coming, so the input must stall
	task automatic test_backpressure();
		configure(16'd4, 16'd4, 16'd4, pick_gain(), pick_gain());
		set_idling(0, 0);
		stall_requests++;
		repeat (24) begin
			if ($urandom_range(1, 0))
				random_store_write(3'($urandom_range(OP_WR_C, OP_WR_A)));
			else
				random_read();
		end
		drain();
	endtask

	task automatic test_random_traffic();
		int phase, quota, stop_at;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: set_idling(0, 0);
				1: set_idling(67, 0);
				2: set_idling(0, 67);
				default: set_idling(31, 31);
			endcase
			quota = (TOTAL_ITEMS - items_sent) / (4 - phase);
			if (quota < 150)
				quota = 150;
			stop_at = items_sent + quota;
			while (items_sent < stop_at)
				random_round();
		end
	endtask

	initial begin
		rows_cfg = DIM_RST;
		cols_cfg = DIM_RST;
		depth_cfg = DIM_RST;
		alpha_cfg = GAIN_UNITY;
		beta_cfg = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_gain_cases();
		test_dim_limits();
		test_backpressure();
		test_random_traffic();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d items, %0d compute runs (%0d clipping), %0d register writes",
			items_sent, computes_run, clipped_runs, reg_writes);
		$display("Checked %0d results, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/smma_pkg.sv
rtl/core/smma_ram.sv
rtl/core/smma_ctrl.sv
rtl/core/smma_dp.sv
rtl/core/scaled_matrix_multiply_accumulate.sv
rtl/core/smma_checker.sv
dv/tb_scaled_matrix_multiply_accumulate.sv
